// File: hw/rtl/f2rdf_pkg.sv
// ----------------------------------------------------------------------------
// f2rdf_pkg
// Constants and constant functions for the float to reduced decimal fraction
// converter: field widths, digit limits, powers of five and ten, and the
// inverses of powers of five modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

package f2rdf_pkg;

  localparam int FLOAT_W = 32;
  localparam int NUM_W = 31;
  localparam int DEN_W = 20;
  localparam int SIG_W = 24;
  localparam int PROD_W = 44;
  localparam int CNT_W = 3;
  localparam int MAX_DIGITS = 6;
  localparam int FRACTION_DIGITS_DEFAULT = 6;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam logic [7:0] EXPO_ALL_ONES = 8'hFF;

  function automatic logic [31:0] pow5(input logic [CNT_W-1:0] k);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < k) begin
        r = 32'(r * 32'd5);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pow10(input logic [CNT_W-1:0] k);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < k) begin
        r = 32'(r * 32'd10);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] inv5(input logic [CNT_W-1:0] k);
    logic [31:0] a;
    logic [31:0] x;
    a = pow5(k);
    x = a;
    for (int i = 0; i < 5; i++) begin
      x = 32'(x * 32'(32'd2 - 32'(a * x)));
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/float_to_reduced_decimal_fraction.sv
// ----------------------------------------------------------------------------
// float_to_reduced_decimal_fraction
// Converts a binary32 pattern to the fraction N/D of its value rounded to a
// fixed number of decimals, with N/D reduced to lowest terms.
// ----------------------------------------------------------------------------
// Usage: a beat is offered by raising start with float_bits valid; it is
// taken at any rising edge where start is high and busy is low. Busy is
// never raised, so one beat may be taken in every cycle.
// Each result beat appears on frac_numerator, frac_denominator and
// range_error for exactly one cycle, marked by done. Results leave in
// input order.
// The work runs through a register pipeline behind the input register: the
// product of the significand with the decimal scale, the exponent shift with
// rounding, the removal of factors of two, the removal of factors of five by
// multiplying with modular inverses, and the output register that forms the
// denominator. Throughput is one beat per cycle.
// Reset clears all valid flags, so no result beat follows reset until a new
// input is taken. The receiver cannot stall; a result beat is present for a
// single cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_reduced_decimal_fraction #(
  parameter int FRACTION_DIGITS = f2rdf_pkg::FRACTION_DIGITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [f2rdf_pkg::FLOAT_W-1:0]   float_bits,
  output logic                                 done,
  output logic [f2rdf_pkg::NUM_W-1:0]          frac_numerator,
  output logic [f2rdf_pkg::DEN_W-1:0]          frac_denominator,
  output logic                                 range_error
);

  import f2rdf_pkg::*;

  localparam logic [CNT_W-1:0] DIGITS = CNT_W'(FRACTION_DIGITS);
  localparam logic [DEN_W-1:0] DSCALE = DEN_W'(pow10(DIGITS));

  // Input register.
  logic               v0;
  logic [FLOAT_W-1:0] bits0;

  // Stage one: product and exponent.
  logic               v1;
  logic [PROD_W-1:0]  p1;
  logic signed [9:0]  e1;
  logic               zero1;
  logic               bad1;
  logic [PROD_W-1:0]  p1_next;
  logic signed [9:0]  e1_next;
  logic               zero1_next;
  logic               bad1_next;

  // Stage two: scaled and rounded numerator.
  logic               v2;
  logic [NUM_W-1:0]   n2;
  logic               zero2;
  logic               err2;
  logic [NUM_W-1:0]   n2_next;
  logic               ovf2;

  // Stage three: factors of two removed.
  logic               v3;
  logic [NUM_W-1:0]   n3;
  logic [CNT_W-1:0]   a3;
  logic               zero3;
  logic               err3;
  logic [CNT_W-1:0]   a3_next;

  // Stage four: factors of five removed.
  logic               v4;
  logic [NUM_W-1:0]   n4;
  logic [CNT_W-1:0]   a4;
  logic [CNT_W-1:0]   b4;
  logic               zero4;
  logic               err4;
  logic [NUM_W-1:0]   n4_next;
  logic [CNT_W-1:0]   b4_next;

  logic [FRACTION_DIGITS-1:0] div5;
  logic [NUM_W-1:0]           quot5 [FRACTION_DIGITS];

  logic [DEN_W-1:0]   den_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    if (start && !busy) begin
      bits0 <= float_bits;
    end
  end

  always_comb begin
    logic [7:0]        expo;
    logic [22:0]       frac;
    logic [SIG_W-1:0]  sig;
    expo = bits0[30:23];
    frac = bits0[22:0];
    zero1_next = (expo == 8'd0) && (frac == 23'd0);
    bad1_next = !zero1_next && ((expo == EXPO_ALL_ONES) || bits0[31]);
    if (expo == 8'd0) begin
      sig = {1'b0, frac};
      e1_next = -10'sd149;
    end else begin
      sig = {1'b1, frac};
      e1_next = $signed({2'b00, expo}) - 10'sd150;
    end
    p1_next = PROD_W'(sig) * PROD_W'(DSCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    p1 <= p1_next;
    e1 <= e1_next;
    zero1 <= zero1_next;
    bad1 <= bad1_next;
  end

  always_comb begin
    logic [4:0]        lsh;
    logic [9:0]        sh;
    logic [5:0]        rsh;
    logic [PROD_W:0]   pext;
    logic [PROD_W:0]   q;
    logic              rbit;
    logic              sticky;
    n2_next = '0;
    ovf2 = 1'b0;
    lsh = '0;
    sh = '0;
    rsh = '0;
    pext = {1'b0, p1};
    q = '0;
    rbit = 1'b0;
    sticky = 1'b0;
    if (!e1[9]) begin
      if (e1 > 10'sd31) begin
        ovf2 = 1'b1;
      end else begin
        lsh = 5'(e1);
        if ((p1 >> (5'd31 - lsh)) != '0) begin
          ovf2 = 1'b1;
        end else begin
          n2_next = NUM_W'(p1 << lsh);
        end
      end
    end else begin
      sh = 10'(-e1);
      if (sh <= 10'd45) begin
        rsh = 6'(sh);
        q = pext >> rsh;
        rbit = pext[rsh - 6'd1];
        sticky = |(pext & (((PROD_W+1)'(1) << (rsh - 6'd1)) - (PROD_W+1)'(1)));
        q = q + (PROD_W+1)'(rbit && (sticky || q[0]));
        if (q > (PROD_W+1)'(NUM_MAX)) begin
          ovf2 = 1'b1;
        end else begin
          n2_next = NUM_W'(q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    n2 <= n2_next;
    err2 <= bad1 || (!zero1 && ovf2);
    zero2 <= zero1 || (n2_next == '0);
  end

  always_comb begin
    a3_next = '0;
    for (int i = 1; i <= FRACTION_DIGITS; i++) begin
      if ((n2 & ((NUM_W'(1) << i) - NUM_W'(1))) == '0) begin
        a3_next = CNT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    n3 <= n2 >> a3_next;
    a3 <= a3_next;
    zero3 <= zero2;
    err3 <= err2;
  end

  for (genvar k = 1; k <= FRACTION_DIGITS; k++) begin : g_five
    localparam logic [31:0] INV = inv5(CNT_W'(k));
    localparam logic [31:0] LIM = 32'(64'hFFFF_FFFF / 64'(pow5(CNT_W'(k))));
    logic [31:0] prod;
    assign prod = 32'({1'b0, n3} * INV);
    assign div5[k-1] = (prod <= LIM);
    assign quot5[k-1] = NUM_W'(prod);
  end

  always_comb begin
    n4_next = n3;
    b4_next = '0;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      if (div5[i]) begin
        n4_next = quot5[i];
        b4_next = CNT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    n4 <= n4_next;
    a4 <= a3;
    b4 <= b4_next;
    zero4 <= zero3;
    err4 <= err3;
  end

  assign den_next = DEN_W'(pow5(DIGITS - b4) << (DIGITS - a4));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    if (err4 || zero4) begin
      frac_numerator <= '0;
      frac_denominator <= DEN_W'(1);
    end else begin
      frac_numerator <= n4;
      frac_denominator <= den_next;
    end
    range_error <= err4;
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for float_to_reduced_decimal_fraction. A directed table
// of binary32 patterns covers zeros, negatives, NaN and infinity, overflow,
// tiny values and exact ties. A weighted random stream follows. Every beat
// taken is predicted by an exact integer model, or by the expected result of
// a typed directed row, and compared with the result beats in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import f2rdf_pkg::*;

  localparam int DIGITS = FRACTION_DIGITS_DEFAULT;
  localparam logic [63:0] DEC_SCALE = 64'(10 ** DIGITS);
  localparam int LATENCY = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 480;
  localparam int N_DIRECTED = 24;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             err;
  } fraction_t;

  typedef struct packed {
    logic [FLOAT_W-1:0] bits;
    logic               typed;
    fraction_t          want;
  } stim_row_t;

  localparam fraction_t ZERO_FRAC = '{31'd0, 20'd1, 1'b0};
  localparam fraction_t ERR_FRAC  = '{31'd0, 20'd1, 1'b1};

  stim_row_t stim_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, ZERO_FRAC},
    '{32'h8000_0000, 1'b1, ZERO_FRAC},
    '{32'h3F80_0000, 1'b1, '{31'd1, 20'd1, 1'b0}},
    '{32'h3F00_0000, 1'b1, '{31'd1, 20'd2, 1'b0}},
    '{32'h3E80_0000, 1'b1, '{31'd1, 20'd4, 1'b0}},
    '{32'h447A_0000, 1'b1, '{31'd1000, 20'd1, 1'b0}},
    '{32'hBF80_0000, 1'b1, ERR_FRAC},
    '{32'h8000_0001, 1'b1, ERR_FRAC},
    '{32'hFFFF_FFFF, 1'b1, ERR_FRAC},
    '{32'h7F80_0000, 1'b1, ERR_FRAC},
    '{32'hFF80_0000, 1'b1, ERR_FRAC},
    '{32'h7FC0_0000, 1'b1, ERR_FRAC},
    '{32'h7F80_0001, 1'b1, ERR_FRAC},
    '{32'h7F7F_FFFF, 1'b1, ERR_FRAC},
    '{32'h4B7F_FFFF, 1'b1, ERR_FRAC},
    '{32'h4506_37BE, 1'b1, ERR_FRAC},
    '{32'h4506_37BD, 1'b0, ZERO_FRAC},
    '{32'h0000_0001, 1'b1, ZERO_FRAC},
    '{32'h007F_FFFF, 1'b1, ZERO_FRAC},
    '{32'h3C00_0000, 1'b0, ZERO_FRAC},
    '{32'h3CC0_0000, 1'b0, ZERO_FRAC},
    '{32'h3DCC_CCCD, 1'b0, ZERO_FRAC},
    '{32'h3F7F_FFFF, 1'b0, ZERO_FRAC},
    '{32'h3540_0000, 1'b0, ZERO_FRAC}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [FLOAT_W-1:0] float_bits = '0;
  logic busy;
  logic done;
  logic [NUM_W-1:0] frac_numerator;
  logic [DEN_W-1:0] frac_denominator;
  logic range_error;

  logic row_typed = 1'b0;
  fraction_t row_want = ZERO_FRAC;

  fraction_t pending_fractions [$];
  int mismatches = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  float_to_reduced_decimal_fraction #(
    .FRACTION_DIGITS(DIGITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .float_bits(float_bits),
    .done(done),
    .frac_numerator(frac_numerator),
    .frac_denominator(frac_denominator),
    .range_error(range_error)
  );

  function automatic fraction_t reduce_float(input logic [FLOAT_W-1:0] bits);
    fraction_t r;
    logic [7:0] ex;
    logic [22:0] mant;
    logic [63:0] sig;
    logic [63:0] prod;
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] den;
    int e;
    int sh;
    r = ZERO_FRAC;
    ex = bits[30:23];
    mant = bits[22:0];
    if (ex == 8'd0 && mant == 23'd0) return r;
    if (ex == EXPO_ALL_ONES || bits[31]) return ERR_FRAC;
    if (ex == 8'd0) begin
      sig = 64'(mant);
      e = -149;
    end else begin
      sig = 64'({1'b1, mant});
      e = int'(ex) - 150;
    end
    prod = sig * DEC_SCALE;
    if (e >= 0) begin
      if (e > 31 || prod > (64'(NUM_MAX) >> e)) return ERR_FRAC;
      n = prod << e;
    end else begin
      sh = -e;
      if (sh >= 64) begin
        n = 64'd0;
      end else begin
        rem = prod & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        n = prod >> sh;
        if (rem > half || (rem == half && n[0])) n = n + 64'd1;
      end
      if (n > 64'(NUM_MAX)) return ERR_FRAC;
    end
    if (n == 64'd0) return r;
    den = DEC_SCALE;
    for (int i = 0; i < DIGITS; i++) begin
      if (!n[0] && !den[0]) begin
        n = n >> 1;
        den = den >> 1;
      end
    end
    for (int i = 0; i < DIGITS; i++) begin
      if (n % 64'd5 == 64'd0 && den % 64'd5 == 64'd0) begin
        n = n / 64'd5;
        den = den / 64'd5;
      end
    end
    r.num = n[NUM_W-1:0];
    r.den = den[DEN_W-1:0];
    return r;
  endfunction

  function automatic logic [FLOAT_W-1:0] random_float();
    int pick;
    logic [7:0] ex;
    logic [22:0] mant;
    pick = $urandom_range(0, 99);
    mant = 23'($urandom);
    if (pick < 55) begin
      ex = 8'($urandom_range(100, 140));
    end else if (pick < 65) begin
      ex = 8'($urandom_range(110, 138));
      mant = mant & (23'h7F_FFFF << $urandom_range(8, 22));
    end else if (pick < 75) begin
      return 32'($urandom);
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: return {$urandom_range(0, 1) == 1, 31'd0};
        1: return {1'b1, 31'($urandom)};
        2: return {1'($urandom_range(0, 1)), EXPO_ALL_ONES, 23'd0};
        default: return {1'($urandom_range(0, 1)), EXPO_ALL_ONES, mant | 23'd1};
      endcase
    end else if (pick < 92) begin
      ex = 8'($urandom_range(0, 106));
    end else begin
      ex = 8'($urandom_range(137, 139));
      mant = 23'(407485 + $urandom_range(0, 16) - 8);
    end
    return {1'b0, ex, mant};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    fraction_t head;
    if (!rst) begin
      if (start && !busy) begin
        pending_fractions.push_back(row_typed ? row_want : reduce_float(float_bits));
      end
      if (done) begin
        if (pending_fractions.size() == 0) begin
          report_mismatch("unexpected result beat, numerator", 64'(frac_numerator), 64'd0);
        end else begin
          head = pending_fractions.pop_front();
          if (frac_numerator != head.num)
            report_mismatch("frac_numerator", 64'(frac_numerator), 64'(head.num));
          if (frac_denominator != head.den)
            report_mismatch("frac_denominator", 64'(frac_denominator), 64'(head.den));
          if (range_error != head.err)
            report_mismatch("range_error", 64'(range_error), 64'(head.err));
        end
      end
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic drive_float(input logic [FLOAT_W-1:0] v, input logic typed,
                             input fraction_t want, input bit allow_idle);
    @(negedge clk);
    if (allow_idle) begin
      while ($urandom_range(0, 99) < 11) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    float_bits <= v;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (stim_rows[i]) begin
      drive_float(stim_rows[i].bits, stim_rows[i].typed, stim_rows[i].want, 1'b1);
    end
    drain_results();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 350) drain_results();
      drive_float(random_float(), 1'b0, ZERO_FRAC, !(i >= 150 && i < 300));
    end
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
